/* hw/rtl/nal_pxs_pkg.sv */
// Shared types, constants and the key table of the NAL payload XOR scrambler.
package nal_pxs_pkg;

    // Frame modes as carried in the input user field.
    localparam logic [1:0] MODE_AUDIO  = 2'd0;
    localparam logic [1:0] MODE_NONKEY = 2'd1;
    localparam logic [1:0] MODE_KEY    = 2'd2;

    // Default configuration of the top level.
    localparam int DEF_KEY_LEN      = 128;
    localparam int DEF_PLAIN_PREFIX = 5;

    // Frame position saturates at this value.
    localparam logic [3:0] POS_MAX = 4'd15;

    // Per-frame decision state, except the key index whose width is a parameter.
    typedef struct packed {
        logic [3:0] pos;
        logic       long_code;
        logic [2:0] skip;
        logic [1:0] mode;
    } t_dec_state;

    // Fixed 128-byte key: a ten-byte prefix, then "123456789-" repeated, ending in "12345678".
    localparam logic [7:0] KEY_ROM [128] = '{
        8'h65, 8'h61, 8'h70, 8'h69, 8'h6c, 8'h2e, 8'h63, 8'h6f, 8'h6d, 8'h2d,
        8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h2d,
        8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h2d,
        8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h2d,
        8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h2d,
        8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h2d,
        8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h2d,
        8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h2d,
        8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h2d,
        8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h2d,
        8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h2d,
        8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h2d,
        8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38
    };

    // Key byte lookup; entries past the table are zero.
    function automatic logic [7:0] key_byte(input logic [7:0] idx);
        logic [7:0] res;
        res = 8'h00;
        if (idx[7] == 1'b0) begin
            res = KEY_ROM[idx[6:0]];
        end
        return res;
    endfunction

endpackage

/* hw/rtl/nal_pxs_decide.sv */
// Decision logic for the oldest byte of the lookahead window.
module nal_pxs_decide
    import nal_pxs_pkg::*;
#(
    parameter int KEY_LEN      = DEF_KEY_LEN,
    parameter int PLAIN_PREFIX = DEF_PLAIN_PREFIX,
    parameter int KW           = (KEY_LEN > 1) ? $clog2(KEY_LEN) : 1
) (
    input  logic [3:0][7:0] i_win,
    input  logic [2:0]      i_count,
    input  t_dec_state      i_state,
    input  logic [KW-1:0]   i_key_idx,
    output logic [7:0]      o_byte,
    output t_dec_state      o_state,
    output logic [KW-1:0]   o_key_idx
);

    localparam logic [3:0]  PREFIX  = 4'(PLAIN_PREFIX);
    localparam logic [KW:0] KEY_END = (KW + 1)'(KEY_LEN);

    logic          do_scr;
    logic          key_clr;
    logic          long_eff;
    logic [2:0]    sc;
    logic          match;
    logic [KW:0]   key_inc;

    // Start-code detection and the per-mode pass or scramble choice.
    always_comb begin
        do_scr   = 1'b0;
        key_clr  = 1'b0;
        o_state  = i_state;
        long_eff = i_state.long_code;
        if (i_state.pos == 4'd0) begin
            long_eff = (i_count >= 3'd4) && (i_win[0] == 8'h00) && (i_win[1] == 8'h00)
                       && (i_win[2] == 8'h00) && (i_win[3] == 8'h01);
        end
        sc    = long_eff ? 3'd4 : 3'd3;
        match = (i_count >= 3'd3) && (i_win[0] == 8'h00) && (i_win[1] == 8'h00)
                && (((sc == 3'd3) && (i_win[2] == 8'h01))
                    || ((i_count >= 3'd4) && (i_win[2] == 8'h00) && (i_win[3] == 8'h01)));
        case (i_state.mode)
            MODE_AUDIO: begin
                do_scr = 1'b1;
            end
            MODE_NONKEY: begin
                do_scr = (i_state.pos >= PREFIX);
            end
            MODE_KEY: begin
                o_state.long_code = long_eff;
                if (i_state.pos < 4'(sc)) begin
                    do_scr = 1'b0;
                end else if (i_state.skip != 3'd0) begin
                    o_state.skip = i_state.skip - 3'd1;
                end else if (match) begin
                    o_state.skip = sc;
                    key_clr      = 1'b1;
                end else begin
                    do_scr = (i_state.pos != 4'(sc));
                end
            end
            default: begin
                do_scr = 1'b0;
            end
        endcase
        if (i_state.pos != POS_MAX) begin
            o_state.pos = i_state.pos + 4'd1;
        end
    end

    // Key XOR and wrapping key index.
    always_comb begin
        key_inc   = {1'b0, i_key_idx} + (KW + 1)'(1);
        o_byte    = i_win[0];
        o_key_idx = i_key_idx;
        if (key_clr) begin
            o_key_idx = '0;
        end else if (do_scr) begin
            o_byte    = i_win[0] ^ key_byte(8'(i_key_idx));
            o_key_idx = (key_inc >= KEY_END) ? '0 : key_inc[KW-1:0];
        end
    end

endmodule

/* hw/rtl/nal_payload_xor_scrambler_unit.sv */
// Top level of the NAL payload XOR scrambler: stream ports, lookahead window and output register.
// A byte passes the input register, the decision logic and the output register; it is decided once
// its three-byte lookahead is complete or its frame's last byte has arrived, and the output is free.
// One byte per cycle inside a frame while the receiver keeps up; at a frame end new input waits
// while the window drains one byte per cycle through the single output register.
// Reset (synchronous, active low) empties the window and both registers and selects audio mode.
module nal_payload_xor_scrambler_unit
    import nal_pxs_pkg::*;
#(
    parameter int KEY_LEN      = DEF_KEY_LEN,
    parameter int PLAIN_PREFIX = DEF_PLAIN_PREFIX
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] byte_in
    input  logic [2:0] i_s_axis_tuser,   // [1:0] kind, [2] frame_first
    input  logic       i_s_axis_tlast,
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] byte_out
    output logic       o_m_axis_tlast
);

    localparam int KW = (KEY_LEN > 1) ? $clog2(KEY_LEN) : 1;

    // Input register.
    logic       r_in_valid;
    logic [7:0] r_in_data;
    logic [1:0] r_in_kind;
    logic       r_in_first;
    logic       r_in_last;

    // Window and frame state.
    logic [2:0][7:0] r_win, n_win;
    logic [1:0]      r_cnt, n_cnt;
    logic            r_tail, n_tail;
    t_dec_state      r_st, n_st;
    logic [KW-1:0]   r_key, n_key;

    // Output register.
    logic       r_out_valid;
    logic [7:0] r_out_data;
    logic       r_out_last;

    logic            append_ok;
    logic            flush_old;
    logic            need_emit;
    logic            slot_free;
    logic            step;
    logic            frame_end;
    logic            in_consume;
    logic [3:0][7:0] view;
    logic [2:0]      view_cnt;
    t_dec_state      eff_st;
    logic [KW-1:0]   eff_key;
    t_dec_state      dec_st;
    logic [KW-1:0]   dec_key;
    logic [7:0]      dec_byte;

    // Sequencing: drain after frame end, flush an unclosed frame, or take the held byte.
    always_comb begin
        flush_old  = r_in_valid && !r_tail && r_in_first && (r_cnt != 2'd0);
        append_ok  = r_in_valid && !r_tail && !flush_old;
        view       = {8'h00, r_win};
        view_cnt   = {1'b0, r_cnt};
        eff_st     = r_st;
        eff_key    = r_key;
        if (append_ok) begin
            view[r_cnt] = r_in_data;
            view_cnt    = {1'b0, r_cnt} + 3'd1;
            if (r_in_first) begin
                eff_st  = '{pos: 4'd0, long_code: 1'b0, skip: 3'd0, mode: r_in_kind};
                eff_key = '0;
            end
        end
        need_emit  = r_tail || flush_old || (append_ok && (r_in_last || (r_cnt == 2'd3)));
        slot_free  = !r_out_valid || i_m_axis_tready;
        step       = need_emit ? slot_free : append_ok;
        frame_end  = (r_tail || flush_old || (append_ok && r_in_last)) && (view_cnt == 3'd1);
        in_consume = append_ok && step;
    end

    nal_pxs_decide #(
        .KEY_LEN      (KEY_LEN),
        .PLAIN_PREFIX (PLAIN_PREFIX),
        .KW           (KW)
    ) u_decide (
        .i_win     (view),
        .i_count   (view_cnt),
        .i_state   (eff_st),
        .i_key_idx (eff_key),
        .o_byte    (dec_byte),
        .o_state   (dec_st),
        .o_key_idx (dec_key)
    );

    // Next window and frame state.
    always_comb begin
        n_win  = r_win;
        n_cnt  = r_cnt;
        n_tail = r_tail;
        n_st   = r_st;
        n_key  = r_key;
        if (step) begin
            if (need_emit) begin
                n_win  = view[3:1];
                n_cnt  = 2'(view_cnt - 3'd1);
                n_tail = (r_tail || (append_ok && r_in_last)) && (view_cnt > 3'd1);
                if (frame_end) begin
                    n_st  = '{pos: 4'd0, long_code: 1'b0, skip: 3'd0, mode: eff_st.mode};
                    n_key = '0;
                end else begin
                    n_st  = dec_st;
                    n_key = dec_key;
                end
            end else begin
                n_win = view[2:0];
                n_cnt = 2'(view_cnt);
                n_st  = eff_st;
                n_key = eff_key;
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cnt       <= 2'd0;
            r_tail      <= 1'b0;
            r_st        <= '{pos: 4'd0, long_code: 1'b0, skip: 3'd0, mode: MODE_AUDIO};
            r_key       <= '0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (step && need_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            r_cnt  <= n_cnt;
            r_tail <= n_tail;
            r_st   <= n_st;
            r_key  <= n_key;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_data  <= i_s_axis_tdata;
            r_in_kind  <= i_s_axis_tuser[1:0];
            r_in_first <= i_s_axis_tuser[2];
            r_in_last  <= i_s_axis_tlast;
        end
        if (step && need_emit) begin
            r_out_data <= dec_byte;
            r_out_last <= frame_end;
        end
        r_win <= n_win;
    end

    assign o_s_axis_tready = !r_in_valid || in_consume;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

    // A drain in progress always has bytes left in the window.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_tail |-> (r_cnt != 2'd0))
        else $error("drain flag set with an empty window");

    // The final byte of a frame leaves a clean frame state behind.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && need_emit && frame_end)
        |=> (r_cnt == 2'd0) && (r_st.pos == 4'd0) && (r_st.skip == 3'd0) && !r_tail)
        else $error("frame state not cleared after frame end");

    // The start-code skip count never exceeds the long code length.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_st.skip <= 3'd4)
        else $error("skip count out of range");

endmodule

/* test/nal_pxs_checker.sv */
// Checker for the NAL payload XOR scrambler: predicts output bytes and compares them.
module nal_pxs_checker
    import nal_pxs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    input  logic       i_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] byte_in
    input  logic [2:0] i_s_tuser,   // [1:0] kind, [2] frame_first
    input  logic       i_s_tlast,
    input  logic       i_m_tvalid,
    input  logic       i_m_tready,
    input  logic [7:0] i_m_tdata,   // [7:0] byte_out
    input  logic       i_m_tlast,
    output int         o_fail_count,
    output int         o_expected_left
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_out_byte;

    // Output bytes predicted but not yet seen on the master side.
    t_out_byte expected_bytes[$];

    // Scrambler state as the predictor tracks it.
    logic [7:0] win [4];
    int         win_cnt;
    logic [3:0] pos;
    logic       long_code;
    logic [2:0] skip;
    logic [6:0] key_idx;
    logic [1:0] mode;

    // Key byte: a fixed ten-byte prefix, then "123456789-" repeated.
    function automatic logic [7:0] key_at(input logic [6:0] idx);
        logic [7:0] res;
        case (idx)
            7'd0: res = 8'h65;
            7'd1: res = 8'h61;
            7'd2: res = 8'h70;
            7'd3: res = 8'h69;
            7'd4: res = 8'h6c;
            7'd5: res = 8'h2e;
            7'd6: res = 8'h63;
            7'd7: res = 8'h6f;
            7'd8: res = 8'h6d;
            7'd9: res = 8'h2d;
            default: res = ((idx - 7'd10) % 10 < 9) ? 8'h31 + 8'((idx - 7'd10) % 10) : 8'h2d;
        endcase
        return res;
    endfunction

    // XOR one byte with the current key byte and step the key index.
    task automatic apply_key(inout logic [7:0] val);
        val = val ^ key_at(key_idx);
        key_idx = key_idx + 7'd1;
    endtask

    task automatic start_frame_state();
        pos = 4'd0;
        long_code = 1'b0;
        skip = 3'd0;
        key_idx = 7'd0;
    endtask

    // Decide the oldest byte of the window, given the bytes that follow it.
    task automatic decide_head(output logic [7:0] res);
        logic [2:0] code_len;
        logic       hit;
        res = win[0];
        case (mode)
            MODE_AUDIO: apply_key(res);
            MODE_NONKEY: begin
                if (pos >= DEF_PLAIN_PREFIX) apply_key(res);
            end
            MODE_KEY: begin
                if (pos == 4'd0) begin
                    long_code = (win_cnt >= 4 && win[0] == 8'h00 && win[1] == 8'h00 &&
                                 win[2] == 8'h00 && win[3] == 8'h01);
                end
                code_len = long_code ? 3'd4 : 3'd3;
                if (pos < code_len) begin
                    // The leading start code passes unchanged.
                end else if (skip > 3'd0) begin
                    skip = skip - 3'd1;
                end else begin
                    hit = win_cnt >= 3 && win[0] == 8'h00 && win[1] == 8'h00 &&
                          ((code_len == 3'd3 && win[2] == 8'h01) ||
                           (win_cnt >= 4 && win[2] == 8'h00 && win[3] == 8'h01));
                    if (hit) begin
                        skip = code_len;
                        key_idx = 7'd0;
                    end else if (pos != code_len) begin
                        apply_key(res);
                    end
                end
            end
            default: begin
                // Mode three passes every byte.
            end
        endcase
        if (pos < POS_MAX) pos = pos + 4'd1;
    endtask

    // Emit the oldest byte and shift the window.
    task automatic shift_out(input logic last_flag);
        t_out_byte item;
        decide_head(item.data);
        item.last = last_flag;
        expected_bytes.push_back(item);
        win[0] = win[1];
        win[1] = win[2];
        win[2] = win[3];
        win[3] = 8'h00;
        win_cnt--;
    endtask

    task automatic drain_window();
        while (win_cnt > 0) shift_out(win_cnt == 1);
        start_frame_state();
    endtask

    // Work out the output bytes caused by one input transaction.
    task automatic predict_transaction(input logic [7:0] data, input logic [1:0] kind,
                                       input logic first, input logic last);
        if (first) begin
            drain_window();
            mode = kind;
        end
        win[win_cnt] = data;
        win_cnt++;
        if (last) begin
            drain_window();
        end else if (win_cnt == 4) begin
            shift_out(1'b0);
        end
    endtask

    // Compare one output transaction with the oldest prediction.
    task automatic check_output(input logic [7:0] data, input logic last);
        t_out_byte want;
        if (expected_bytes.size() == 0) begin
            if (o_fail_count < REPORT_LIMIT) begin
                $display("%0t: unexpected output byte %02h last %0b", $time, data, last);
            end
            o_fail_count++;
        end else begin
            want = expected_bytes.pop_front();
            if (data !== want.data || last !== want.last) begin
                if (o_fail_count < REPORT_LIMIT) begin
                    $display("%0t: mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                             $time, want.data, want.last, data, last);
                end
                o_fail_count++;
            end
        end
    endtask

    // Outputs are checked before the same edge's input is predicted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_bytes.delete();
            foreach (win[k]) win[k] = 8'h00;
            win_cnt = 0;
            mode = MODE_AUDIO;
            start_frame_state();
            o_fail_count = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) check_output(i_m_tdata, i_m_tlast);
            if (i_s_tvalid && i_s_tready) begin
                predict_transaction(i_s_tdata, i_s_tuser[1:0], i_s_tuser[2], i_s_tlast);
            end
        end
        o_expected_left = expected_bytes.size();
    end

endmodule

/* test/testbench.sv */
// Top of the scrambler testbench: clock, reset, stimulus, receiver stalls and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import nal_pxs_pkg::*;

    localparam logic [1:0] MODE_PASS = 2'd3;
    localparam int IDLE_LIMIT    = 1000;
    localparam int HOLD_CYCLES   = 60;
    localparam int RANDOM_BYTES  = 290;
    localparam int SETTLE_CYCLES = 20;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;    // [7:0] byte_in
    logic [2:0] s_tuser;    // [1:0] kind, [2] frame_first
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;    // [7:0] byte_out
    logic       m_tlast;

    int         fail_count;
    int         expected_left;
    int         stall_cycles = 0;
    int         bytes_sent = 0;
    bit         burst_phase = 1'b0;
    bit         hold_request = 1'b0;
    logic [7:0] frame_bytes[$];

    always #5 i_clk = ~i_clk;

    nal_payload_xor_scrambler_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast)
    );

    nal_pxs_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_tvalid      (s_tvalid),
        .i_s_tready      (s_tready),
        .i_s_tdata       (s_tdata),
        .i_s_tuser       (s_tuser),
        .i_s_tlast       (s_tlast),
        .i_m_tvalid      (m_tvalid),
        .i_m_tready      (m_tready),
        .i_m_tdata       (m_tdata),
        .i_m_tlast       (m_tlast),
        .o_fail_count    (fail_count),
        .o_expected_left (expected_left)
    );

    // Watchdog: end the run when no transaction happens for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver: random stalls per byte, and one long hold-off on request.
    initial begin
        int gap;
        m_tready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            gap = burst_phase ? 0 : $urandom_range(0, 4);
            repeat (gap) begin
                m_tready <= 1'b0;
                @(negedge i_clk);
            end
            m_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_tvalid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    // Offer one byte after a random gap and wait for its transaction.
    task automatic send_byte(input logic [7:0] data, input logic [1:0] kind,
                             input logic first, input logic last);
        int gap;
        gap = burst_phase ? 0 : $urandom_range(0, 4);
        repeat (gap) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= {first, kind};
        s_tlast  <= last;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // Send the bytes held in frame_bytes; kind is random where the block ignores it.
    task automatic send_frame(input logic [1:0] kind, input bit with_first, input bit with_last);
        int n;
        n = frame_bytes.size();
        for (int i = 0; i < n; i++) begin
            send_byte(frame_bytes[i], (i == 0) ? kind : 2'($urandom_range(0, 3)),
                      with_first && i == 0, with_last && i == n - 1);
        end
    endtask

    // Start code of three or four bytes and a random header byte.
    task automatic append_start_code();
        if ($urandom_range(0, 1)) frame_bytes.push_back(8'h00);
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back(8'h01);
        frame_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    // Key frame: mostly well-formed with embedded start codes and near misses.
    task automatic build_key_frame();
        int target;
        frame_bytes.delete();
        if ($urandom_range(0, 7) == 0) begin
            target = $urandom_range(1, 8);
            repeat (target) begin
                frame_bytes.push_back($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(0, 255)));
            end
        end else begin
            append_start_code();
            target = $urandom_range(6, 28);
            while (frame_bytes.size() < target) begin
                case ($urandom_range(0, 5))
                    0: append_start_code();
                    1: begin
                        frame_bytes.push_back(8'h00);
                        frame_bytes.push_back(8'h00);
                        frame_bytes.push_back(8'($urandom_range(0, 2)));
                    end
                    2: frame_bytes.push_back(8'h00);
                    default: frame_bytes.push_back(8'($urandom_range(0, 255)));
                endcase
            end
        end
    endtask

    task automatic build_plain_frame(input int len);
        frame_bytes.delete();
        repeat (len) frame_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    // Stimulus and verdict.
    initial begin
        int         frame_idx;
        int         random_start;
        int         pick;
        logic [1:0] kind;

        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        s_tuser  = 3'b000;
        s_tlast  = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames: every mode, data extremes, leading codes, unclosed frames.
        frame_bytes = '{8'h00, 8'hFF, 8'hA5};
        send_frame(MODE_AUDIO, 1'b1, 1'b1);
        frame_bytes = '{8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66};
        send_frame(MODE_NONKEY, 1'b1, 1'b1);
        frame_bytes = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h09, 8'h00,
                        8'h00, 8'h00, 8'h01, 8'h44, 8'h77};
        send_frame(MODE_KEY, 1'b1, 1'b1);
        // Mode three frame left open, then closed by the next frame start.
        frame_bytes = '{8'hC3, 8'h3C};
        send_frame(MODE_PASS, 1'b1, 1'b0);
        frame_bytes = '{8'h00, 8'h00, 8'h01};
        send_frame(MODE_KEY, 1'b1, 1'b1);
        // Bytes without a frame start continue in the last mode.
        frame_bytes = '{8'h00, 8'h00};
        send_frame(MODE_KEY, 1'b0, 1'b1);

        // Random frames.
        random_start = bytes_sent;
        frame_idx = 0;
        while (bytes_sent - random_start < RANDOM_BYTES) begin
            burst_phase = ($urandom_range(0, 3) == 0);
            if (frame_idx == 4) hold_request = 1'b1;
            if (frame_idx == 2) begin
                // Let every result drain before going on.
                s_tvalid <= 1'b0;
                wait (expected_left == 0);
                @(negedge i_clk);
            end
            pick = $urandom_range(0, 9);
            if (frame_idx == 3) begin
                // One long audio frame makes the key index wrap.
                kind = MODE_AUDIO;
                build_plain_frame(135);
            end else if (pick < 2) begin
                kind = MODE_AUDIO;
                build_plain_frame($urandom_range(1, 12));
            end else if (pick < 4) begin
                kind = MODE_NONKEY;
                build_plain_frame($urandom_range(1, 12));
            end else if (pick < 9) begin
                kind = MODE_KEY;
                build_key_frame();
            end else begin
                kind = MODE_PASS;
                build_plain_frame($urandom_range(1, 6));
            end
            send_frame(kind, $urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0);
            frame_idx++;
        end

        // Close whatever frame is still open so that every byte comes out.
        burst_phase = 1'b0;
        send_byte(8'($urandom_range(0, 255)), MODE_AUDIO, 1'b0, 1'b1);
        s_tvalid <= 1'b0;

        wait (expected_left == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && expected_left == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
